// ===== rtl/dspm_pkg.sv =====
// ----------------------------------------------------------------------------
// dspm_pkg
// Shared constants and types for the dot-star pattern matcher.
// ----------------------------------------------------------------------------
package dspm_pkg;

   localparam int unsigned CHAR_W         = 8;
   localparam int unsigned LEN_W          = 6;
   localparam int unsigned CSR_IDX_W      = 3;
   localparam int unsigned CSR_DATA_W     = 64;
   localparam int unsigned NUM_WORDS      = 4;
   localparam int unsigned CHARS_PER_WORD = CSR_DATA_W / CHAR_W;
   localparam int unsigned REG_CHARS      = NUM_WORDS * CHARS_PER_WORD;

   localparam logic [CHAR_W-1:0] DOT_CHAR  = 8'h2E;
   localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;

   // Register indexes of the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LENGTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_0 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_2 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_WORD_3 = 3'd4;

   // Input word actions
   localparam logic ACTION_START  = 1'b0;
   localparam logic ACTION_APPEND = 1'b1;

   typedef struct packed {
      logic valid;
      logic full;
   } fifo_status_type;

endpackage

// ===== rtl/dspm_decode.sv =====
// ----------------------------------------------------------------------------
// dspm_decode
// Pattern registers and a sweep that derives the element tables from them.
// ----------------------------------------------------------------------------
module dspm_decode #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [dspm_pkg::CSR_IDX_W-1:0]                csr_index,
   input  logic [dspm_pkg::CSR_DATA_W-1:0]               csr_wdata,
   output logic                                          busy,
   output logic [$clog2(MAX_PATTERN+1)-1:0]              ulen,
   output logic [MAX_PATTERN-1:0][dspm_pkg::CHAR_W-1:0]  pat_chars,
   output logic [MAX_PATTERN:0]                          star_start,
   output logic [MAX_PATTERN:0]                          plain_start,
   output logic [MAX_PATTERN:0][MAX_PATTERN:0]           reach
);
   import dspm_pkg::*;

   localparam int unsigned RowW = MAX_PATTERN + 1;
   localparam int unsigned PosW = $clog2(MAX_PATTERN + 1);

   logic [LEN_W-1:0]                      length_ff;
   logic [NUM_WORDS-1:0][CSR_DATA_W-1:0]  word_ff;
   logic [LEN_W:0]                        len_ext;
   logic [LEN_W:0]                        len_cap;
   logic [RowW-1:0]                       star_m;

   logic                                  clear_ff;
   logic                                  busy_ff;
   logic [PosW-1:0]                       pos_ff;
   logic                                  start_ff;
   logic [RowW-1:0]                       run_ff;
   logic [RowW-1:0]                       star_start_ff;
   logic [RowW-1:0]                       plain_start_ff;
   logic [RowW-1:0][RowW-1:0]             reach_ff;

   logic                                  at_end;
   logic [PosW-1:0]                       nxt_idx;
   logic                                  starred;
   logic [RowW-1:0]                       pos_bit;
   logic [RowW-1:0]                       row_val;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         word_ff   <= '0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_PATTERN_LENGTH: length_ff  <= csr_wdata[LEN_W-1:0];
            CSR_PATTERN_WORD_0: word_ff[0] <= csr_wdata;
            CSR_PATTERN_WORD_1: word_ff[1] <= csr_wdata;
            CSR_PATTERN_WORD_2: word_ff[2] <= csr_wdata;
            CSR_PATTERN_WORD_3: word_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Saturate the length to the number of positions built
   assign len_ext = {1'b0, length_ff};
   assign len_cap = (len_ext > (LEN_W+1)'(MAX_PATTERN)) ? (LEN_W+1)'(MAX_PATTERN) : len_ext;
   assign ulen    = PosW'(len_cap);

   for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_chars
      if (k < REG_CHARS) begin : g_reg
         assign pat_chars[k] =
            word_ff[k / CHARS_PER_WORD][(k % CHARS_PER_WORD)*CHAR_W +: CHAR_W];
      end else begin : g_zero
         assign pat_chars[k] = '0;
      end
   end

   always_comb begin
      star_m = '0;
      for (int k = 0; k < MAX_PATTERN; k++) begin
         star_m[k] = (pat_chars[k] == STAR_CHAR) && (ulen > PosW'(k));
      end
   end

   // One pattern position per cycle
   assign at_end  = (pos_ff == ulen);
   assign nxt_idx = PosW'(pos_ff + 1'b1);
   assign starred = !at_end && start_ff && star_m[nxt_idx];
   assign pos_bit = RowW'(1) << pos_ff;
   assign row_val = (start_ff || at_end) ? (run_ff | pos_bit) : '0;

   always_ff @(posedge clock) begin
      if (reset || csr_valid) begin
         clear_ff <= 1'b1;
         busy_ff  <= 1'b1;
         pos_ff   <= '0;
         start_ff <= 1'b1;
         run_ff   <= '0;
      end else if (clear_ff) begin
         clear_ff <= 1'b0;
      end else if (busy_ff) begin
         if (at_end) begin
            busy_ff <= 1'b0;
         end else begin
            pos_ff <= nxt_idx;
            if (!start_ff) begin
               start_ff <= 1'b1;
            end else if (starred) begin
               start_ff <= 1'b0;
               run_ff   <= run_ff | pos_bit;
            end else begin
               start_ff <= 1'b1;
               run_ff   <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clear_ff) begin
         star_start_ff  <= '0;
         plain_start_ff <= '0;
         reach_ff       <= '0;
      end else if (busy_ff) begin
         reach_ff[pos_ff] <= row_val;
         if (!at_end && start_ff) begin
            if (starred) begin
               star_start_ff[pos_ff] <= 1'b1;
            end else begin
               plain_start_ff[pos_ff] <= 1'b1;
            end
         end
      end
   end

   assign busy        = busy_ff;
   assign star_start  = star_start_ff;
   assign plain_start = plain_start_ff;
   assign reach       = reach_ff;

   a_starts_disjoint: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> ((star_start_ff & plain_start_ff) == '0))
      else $error("element start marked both starred and plain");

   a_end_reachable: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> reach_ff[ulen][ulen])
      else $error("end boundary missing from its own reach row");

endmodule

// ===== rtl/dspm_front.sv =====
// ----------------------------------------------------------------------------
// dspm_front
// Accept input words and classify the text byte against every pattern char.
// ----------------------------------------------------------------------------
module dspm_front #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic                                          req_action,
   input  logic [dspm_pkg::CHAR_W-1:0]                   req_text_char,
   input  logic                                          busy,
   input  dspm_pkg::fifo_status_type                     q_status,
   input  logic [MAX_PATTERN-1:0][dspm_pkg::CHAR_W-1:0]  pat_chars,
   output logic                                          push,
   output logic                                          push_action,
   output logic [MAX_PATTERN-1:0]                        push_hit
);
   import dspm_pkg::*;

   // Hold off while the pattern tables rebuild or the queue is full
   assign req_stall   = busy | q_status.full;
   assign push        = req_valid & !req_stall;
   assign push_action = req_action;

   always_comb begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
         push_hit[k] = (pat_chars[k] == DOT_CHAR) || (pat_chars[k] == req_text_char);
      end
   end

endmodule

// ===== rtl/dspm_queue.sv =====
// ----------------------------------------------------------------------------
// dspm_queue
// Two-entry queue between the classifying front and the row-update back.
// ----------------------------------------------------------------------------
module dspm_queue #(
   parameter int unsigned WIDTH = 33
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output dspm_pkg::fifo_status_type  status
);
   import dspm_pkg::*;

   localparam int unsigned Depth = 2;

   logic [WIDTH-1:0] mem_ff [Depth];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 2'd1;
            2'b01:   count_ff <= count_ff - 2'd1;
            default: count_ff <= count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = mem_ff[rd_ptr_ff];
   assign status.valid = (count_ff != 2'd0);
   assign status.full  = (count_ff == 2'(Depth));

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(Depth))
      else $error("queue count beyond depth");

endmodule

// ===== rtl/dspm_back.sv =====
// ----------------------------------------------------------------------------
// dspm_back
// Advance the live row one word per unstalled cycle and register the result.
// ----------------------------------------------------------------------------
module dspm_back #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dspm_pkg::fifo_status_type            q_status,
   input  logic                                 q_action,
   input  logic [MAX_PATTERN-1:0]               q_hit,
   output logic                                 pop,
   input  logic [MAX_PATTERN:0]                 star_start,
   input  logic [MAX_PATTERN:0]                 plain_start,
   input  logic [MAX_PATTERN:0][MAX_PATTERN:0]  reach,
   input  logic [$clog2(MAX_PATTERN+1)-1:0]     ulen,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_prefix_matches,
   output logic                                 rsp_no_match_possible
);
   import dspm_pkg::*;

   localparam int unsigned RowW = MAX_PATTERN + 1;

   logic [RowW-1:0] live_ff;
   logic            rsp_valid_ff;
   logic            match_ff;
   logic            dead_ff;

   logic [RowW-1:0] live_hit;
   logic [RowW-1:0] pre_row;
   logic [RowW-1:0] next_row;

   assign pop = q_status.valid && (!rsp_valid_ff || !rsp_stall);

   assign live_hit = live_ff & {1'b0, q_hit};
   assign pre_row  = (q_action == ACTION_START) ? RowW'(1) :
                     ((live_hit & star_start) | ((live_hit & plain_start) << 1));

   // Zero repetitions of starred elements: fold in every boundary that reaches j
   always_comb begin
      for (int j = 0; j < RowW; j++) begin
         next_row[j] = |(pre_row & reach[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (pop) begin
         live_ff      <= next_row;
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         match_ff <= next_row[ulen];
         dead_ff  <= ~|next_row;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_prefix_matches    = match_ff;
   assign rsp_no_match_possible = dead_ff;

   a_match_is_live: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && match_ff |-> !dead_ff)
      else $error("match reported with an empty row");

   a_start_live: assert property (@(posedge clock) disable iff (reset)
      pop && (q_action == ACTION_START) |=> rsp_valid_ff && !dead_ff && live_ff[0])
      else $error("start word did not leave boundary zero live");

   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("popped word produced no result");

endmodule

// ===== rtl/dot_star_pattern_matcher_top.sv =====
// An accepted word enters the queue; its pop updates the live row and the result.
// Throughput: one word per cycle unless rsp_stall or a table rebuild holds it off.
// Reset: synchronous, active high; clears the pattern, the live row and all valids.
// After reset and after every csr write the pattern tables rebuild over the
// saturated pattern length, with req_stall held high.
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher_top
// Streaming matcher for patterns of literals, '.' and '*' over a text stream.
// ----------------------------------------------------------------------------
module dot_star_pattern_matcher_top #(
   parameter int unsigned MAX_PATTERN = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // Input words
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_action,
   input  logic [dspm_pkg::CHAR_W-1:0]       req_text_char,
   // Result words
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_prefix_matches,
   output logic                              rsp_no_match_possible,
   // Configuration
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [dspm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [dspm_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import dspm_pkg::*;

   localparam int unsigned RowW   = MAX_PATTERN + 1;
   localparam int unsigned PosW   = $clog2(MAX_PATTERN + 1);
   localparam int unsigned EntryW = MAX_PATTERN + 1;

   // Pattern tables from the decoder
   logic                                busy;
   logic [PosW-1:0]                     ulen;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0]  pat_chars;
   logic [RowW-1:0]                     star_start;
   logic [RowW-1:0]                     plain_start;
   logic [RowW-1:0][RowW-1:0]           reach;

   // Front to queue
   logic                                push;
   logic                                push_action;
   logic [MAX_PATTERN-1:0]              push_hit;

   // Queue to back
   fifo_status_type                     q_status;
   logic [EntryW-1:0]                   q_data;
   logic                                pop;

   // The decoder owns the csr registers. Each write restarts a sweep over the
   // pattern that marks element starts (starred or plain) and, for every
   // boundary, the set of earlier boundaries that reach it by skipping
   // starred elements. The sweep is serial because the element split depends
   // on everything to its left.
   dspm_decode #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_decode (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .busy        (busy),
      .ulen        (ulen),
      .pat_chars   (pat_chars),
      .star_start  (star_start),
      .plain_start (plain_start),
      .reach       (reach)
   );

   // Front: take the word and compare its byte with every pattern character
   // at once; the hit vector is all the back needs of the text.
   dspm_front #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_action    (req_action),
      .req_text_char (req_text_char),
      .busy          (busy),
      .q_status      (q_status),
      .pat_chars     (pat_chars),
      .push          (push),
      .push_action   (push_action),
      .push_hit      (push_hit)
   );

   // Two entries let the front keep taking words while a result waits on rsp_stall
   dspm_queue #(
      .WIDTH (EntryW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_action, push_hit}),
      .pop       (pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   // Back: advance the live row by one word, apply the star closure and
   // register the two result bits in the output stage.
   dspm_back #(
      .MAX_PATTERN (MAX_PATTERN)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .q_status              (q_status),
      .q_action              (q_data[EntryW-1]),
      .q_hit                 (q_data[MAX_PATTERN-1:0]),
      .pop                   (pop),
      .star_start            (star_start),
      .plain_start           (plain_start),
      .reach                 (reach),
      .ulen                  (ulen),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_prefix_matches    (rsp_prefix_matches),
      .rsp_no_match_possible (rsp_no_match_possible)
   );

endmodule

// ===== verif/dot_star_pattern_matcher_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dot_star_pattern_matcher testbench
// Streams start and character words through the matcher under several
// patterns and compares every result word with an element-walking row predictor.
// Directed words cover text before any start, the empty and full-length
// patterns, literal '*', '.', byte zero and a pattern changed mid-text.
// Random streams then follow, with stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;
   import dspm_pkg::*;

   localparam int MAX_PAT        = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int MAX_REPORTS    = 40;
   localparam int WORD_SEL_W     = $clog2(NUM_WORDS);

   localparam logic [CSR_IDX_W-1:0] WORD_INDEX [NUM_WORDS] = '{
      CSR_PATTERN_WORD_0, CSR_PATTERN_WORD_1, CSR_PATTERN_WORD_2, CSR_PATTERN_WORD_3
   };

   typedef struct packed {
      logic prefix_matches;
      logic no_match_possible;
   } match_flags_type;

   // Block ports; every input holds a known value from time zero
   logic                  clock        = 1'b0;
   logic                  reset        = 1'b1;
   logic                  req_valid    = 1'b0;
   logic                  req_stall;
   logic                  req_action   = ACTION_START;
   logic [CHAR_W-1:0]     req_text_char = '0;
   logic                  rsp_valid;
   logic                  rsp_stall    = 1'b0;
   logic                  rsp_prefix_matches;
   logic                  rsp_no_match_possible;
   logic                  csr_valid    = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index    = CSR_PATTERN_LENGTH;
   logic [CSR_DATA_W-1:0] csr_wdata    = '0;

   // Predictor copy of the pattern registers and the live row
   logic [LEN_W-1:0]      pattern_len_reg = '0;
   logic [CSR_DATA_W-1:0] pattern_regs [NUM_WORDS] = '{default: '0};
   logic [MAX_PAT:0]      live_row = '0;

   match_flags_type       pending_flags [$];

   // Run bookkeeping
   bit idling_on     = 1'b0;
   int mismatches    = 0;
   int words_sent    = 0;
   int starts_sent   = 0;
   int csr_writes    = 0;
   int results_seen  = 0;
   int matches_seen  = 0;
   int dead_rows     = 0;
   int quiet_cycles  = 0;
   int stall_left    = 0;

   dot_star_pattern_matcher_top #(
      .MAX_PATTERN (MAX_PAT)
   ) i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_text_char         (req_text_char),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_prefix_matches    (rsp_prefix_matches),
      .rsp_no_match_possible (rsp_no_match_possible),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   always #5 clock = ~clock;

   // ------------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------------

   // Lengths above the row size saturate.
   function automatic int used_length();
      int n;
      n = pattern_len_reg;
      return (n > MAX_PAT) ? MAX_PAT : n;
   endfunction

   // Characters beyond the registers read as byte zero.
   function automatic logic [CHAR_W-1:0] pattern_char(int k);
      if (k >= REG_CHARS)
         return '0;
      return pattern_regs[WORD_SEL_W'(k / CHARS_PER_WORD)]
                         [(k % CHARS_PER_WORD) * CHAR_W +: CHAR_W];
   endfunction

   // An element carries a star when the character after its head is '*'.
   function automatic logic element_starred(int k, int len);
      return (k + 1 < len) && (pattern_char(k + 1) == STAR_CHAR);
   endfunction

   // Advance the live boundary row by one word and derive the result flags.
   function automatic match_flags_type advance_live_row(logic action, logic [CHAR_W-1:0] ch);
      logic [MAX_PAT:0]  next_row;
      match_flags_type   flags;
      logic [CHAR_W-1:0] c;
      logic              starred;
      int                len;
      int                k;
      int                step;
      len      = used_length();
      next_row = '0;
      if (action == ACTION_START) begin
         next_row[0] = 1'b1;
      end else begin
         k = 0;
         while (k < len) begin
            c       = pattern_char(k);
            starred = element_starred(k, len);
            step    = starred ? 2 : 1;
            if (live_row[k] && (c == DOT_CHAR || c == ch)) begin
               // a starred element loops on itself, a plain one moves on
               if (starred)
                  next_row[k] = 1'b1;
               else
                  next_row[k + step] = 1'b1;
            end
            k += step;
         end
      end
      // skip starred elements taken zero times, left to right so chains close
      k = 0;
      while (k < len) begin
         starred = element_starred(k, len);
         if (starred && next_row[k])
            next_row[k + 2] = 1'b1;
         k += starred ? 2 : 1;
      end
      live_row                = next_row;
      flags.prefix_matches    = live_row[len];
      flags.no_match_possible = ~|live_row;
      return flags;
   endfunction

   // ------------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------------

   // Offer one word, hold it until taken, predict its result, then maybe idle.
   task automatic send_word(logic action, logic [CHAR_W-1:0] ch);
      int gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_action    <= action;
      req_text_char <= ch;
      do
         @(posedge clock);
      while (req_stall);
      pending_flags.push_back(advance_live_row(action, ch));
      words_sent++;
      if (action == ACTION_START)
         starts_sent++;
      if (idling_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 11);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   // Drop valid and hold the sender until every expected result has come.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_flags.size() != 0)
         @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      if (idx == CSR_PATTERN_LENGTH)
         pattern_len_reg = data[LEN_W-1:0];
      else
         pattern_regs[WORD_SEL_W'(idx - CSR_PATTERN_WORD_0)] = data;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Write all four pattern words, then the length, with the block idle.
   task automatic write_pattern(logic [REG_CHARS*CHAR_W-1:0] chars, logic [LEN_W-1:0] len_code);
      wait_drained();
      for (int w = 0; w < NUM_WORDS; w++)
         csr_write(WORD_INDEX[w], chars[w * CSR_DATA_W +: CSR_DATA_W]);
      csr_write(CSR_PATTERN_LENGTH, CSR_DATA_W'(len_code));
   endtask

   // '~' in the string stands for byte zero and '^' for byte 0xFF.
   task automatic load_pattern(string s, logic [LEN_W-1:0] len_code);
      logic [REG_CHARS*CHAR_W-1:0] chars;
      logic [CHAR_W-1:0]           b;
      chars = '0;
      for (int i = 0; i < s.len() && i < REG_CHARS; i++) begin
         b = s[i];
         if (b == "~")
            b = 8'h00;
         else if (b == "^")
            b = 8'hFF;
         chars[i * CHAR_W +: CHAR_W] = b;
      end
      write_pattern(chars, len_code);
   endtask

   // Skew both alphabets towards a few letters so that matches actually happen.
   function automatic logic [CHAR_W-1:0] pick_pattern_char();
      int r;
      r = $urandom_range(0, 11);
      if (r <= 3) return "a";
      if (r <= 5) return "b";
      if (r == 6) return "c";
      if (r <= 8) return DOT_CHAR;
      if (r <= 10) return STAR_CHAR;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CHAR_W-1:0] pick_text_char();
      int r;
      r = $urandom_range(0, 9);
      if (r <= 3) return "a";
      if (r <= 5) return "b";
      if (r == 6) return "c";
      if (r == 7) return STAR_CHAR;
      if (r == 8) return DOT_CHAR;
      return CHAR_W'($urandom_range(0, 255));
   endfunction

   task automatic randomise_pattern();
      logic [REG_CHARS*CHAR_W-1:0] chars;
      logic [LEN_W-1:0]            len_code;
      for (int i = 0; i < REG_CHARS; i++)
         chars[i * CHAR_W +: CHAR_W] = pick_pattern_char();
      // mostly short patterns, now and then anything the field allows
      if ($urandom_range(0, 5) == 0)
         len_code = LEN_W'($urandom_range(0, 63));
      else
         len_code = LEN_W'($urandom_range(0, 8));
      write_pattern(chars, len_code);
   endtask

   // Mostly start-then-text runs, with loose noise words mixed in.
   task automatic run_stream_phase(int n_words);
      int sent;
      int run_len;
      sent = 0;
      while (sent < n_words) begin
         if ($urandom_range(0, 7) == 0) begin
            send_word(1'($urandom_range(0, 1)), CHAR_W'($urandom_range(0, 255)));
            sent++;
         end else begin
            send_word(ACTION_START, CHAR_W'($urandom_range(0, 255)));
            run_len = $urandom_range(0, 10);
            repeat (run_len) send_word(ACTION_APPEND, pick_text_char());
            sent += run_len + 1;
         end
         if ($urandom_range(0, 19) == 0)
            wait_drained();
      end
   endtask

   // ------------------------------------------------------------------------
   // Result side: random stall bursts, checking, watchdog
   // ------------------------------------------------------------------------

   always @(negedge clock) begin
      if (reset || !idling_on) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else begin
         if (stall_left == 0 && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
         rsp_stall <= (stall_left != 0);
         if (stall_left != 0)
            stall_left--;
      end
   end

   task automatic report_mismatch(string what);
      if (mismatches < MAX_REPORTS)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatches++;
   endtask

   always @(posedge clock) begin : check_results
      match_flags_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_prefix_matches)
            matches_seen++;
         if (rsp_no_match_possible)
            dead_rows++;
         if (pending_flags.size() == 0) begin
            report_mismatch("result word with nothing expected");
         end else begin
            want = pending_flags.pop_front();
            if (rsp_prefix_matches !== want.prefix_matches)
               report_mismatch($sformatf("prefix_matches got %b expected %b",
                                         rsp_prefix_matches, want.prefix_matches));
            if (rsp_no_match_possible !== want.no_match_possible)
               report_mismatch($sformatf("no_match_possible got %b expected %b",
                                         rsp_no_match_possible, want.no_match_possible));
         end
      end
   end

   // Count cycles with no handshake on any channel; the csr rebuild is the longest
   // legitimate quiet stretch, well under the limit.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: %0d cycles without a handshake, %0d results outstanding",
                  quiet_cycles, pending_flags.size());
         $display("status: fail");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Text before any start: row is empty, nothing can match.
   task automatic test_text_before_start();
      send_word(ACTION_APPEND, 8'h00);
      send_word(ACTION_APPEND, 8'hFF);
      send_word(ACTION_APPEND, STAR_CHAR);
   endtask

   // Reset length of zero: only the empty text matches.
   task automatic test_empty_pattern();
      send_word(ACTION_START, 8'hFF);
      send_word(ACTION_APPEND, "a");
      send_word(ACTION_START, 8'h00);
   endtask

   // Leading '*' is a literal, 'a*' repeats, '.' takes anything, byte zero and
   // 0xFF compare as plain literals.
   task automatic test_literals_and_wildcards();
      load_pattern("*a*.~^", 6);
      send_word(ACTION_START, 8'h00);
      send_word(ACTION_APPEND, STAR_CHAR);
      send_word(ACTION_APPEND, "a");
      send_word(ACTION_APPEND, "a");
      send_word(ACTION_APPEND, "q");
      send_word(ACTION_APPEND, 8'h00);
      send_word(ACTION_APPEND, 8'hFF);
      send_word(ACTION_APPEND, 8'hFF);
   endtask

   // Length code 63 saturates to the full 32 characters.
   task automatic test_saturated_length();
      load_pattern(".*.*.*.*.*.*.*.*.*.*.*.*.*.*.*.*", 6'h3F);
      send_word(ACTION_START, "z");
      send_word(ACTION_APPEND, "x");
      send_word(ACTION_APPEND, 8'hFF);
   endtask

   // Swap the pattern mid-text after earlier results drain; the row is kept and
   // only the new element boundaries are read.
   task automatic test_pattern_change_mid_text();
      load_pattern("ab*c", 4);
      send_word(ACTION_APPEND, "a");
      send_word(ACTION_APPEND, "b");
      send_word(ACTION_APPEND, "c");
   endtask

   task automatic test_random_streams();
      repeat (7) begin
         randomise_pattern();
         idling_on = ($urandom_range(0, 3) != 0);
         run_stream_phase(55);
      end
   endtask

   // Closing stretch at full rate on both sides.
   task automatic test_back_to_back();
      randomise_pattern();
      idling_on = 1'b0;
      run_stream_phase(40);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      test_text_before_start();
      test_empty_pattern();
      test_literals_and_wildcards();
      test_saturated_length();
      test_pattern_change_mid_text();
      test_random_streams();
      test_back_to_back();

      wait_drained();
      repeat (4) @(posedge clock);

      $display("covered %0d words (%0d starts) across %0d register writes and several patterns",
               words_sent, starts_sent, csr_writes);
      $display("checked %0d results: %0d full matches, %0d dead rows, %0d mismatches",
               results_seen, matches_seen, dead_rows, mismatches);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
